### design/fiq_pkg.sv
`default_nettype none

package fiq_pkg;

    localparam int CYLINDERS_DEF = 4;
    localparam int MASK_W        = 4;
    localparam int VOLT_W        = 16;
    localparam int TIMER_W       = 16;
    localparam int CNT_W         = 8;
    localparam int CYL_W         = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_VOLT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_VOLT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_DLY  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_THR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_THR  = 3'd4;

    localparam logic [TIMER_W-1:0] ENABLE_DLY_RST = 16'd64;
    localparam logic [CNT_W-1:0]   FAIL_THR_RST   = 8'd5;
    localparam logic [CNT_W-1:0]   SAMPLE_THR_RST = 8'd10;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_EVENT = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [VOLT_W-1:0] ign_voltage;
        logic              ign_on;
        logic [CYL_W-1:0]  cylinder;
        logic              short_fault;
        logic              open_fault;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] short_failed_mask;
        logic [MASK_W-1:0] open_failed_mask;
        logic [MASK_W-1:0] short_done_mask;
        logic [MASK_W-1:0] open_done_mask;
        logic [MASK_W-1:0] any_done_mask;
        logic              short_check_enabled;
        logic              open_check_enabled;
    } t_out_item;

    typedef struct packed {
        logic              enable;
        logic [MASK_W-1:0] done;
        logic [MASK_W-1:0] failed;
    } t_class_rpt;

    typedef struct packed {
        logic [TIMER_W-1:0] delay;
        logic [CNT_W-1:0]   fail_thr;
        logic [CNT_W-1:0]   sample_thr;
    } t_class_cfg;

endpackage

`default_nettype wire

### design/fiq_class.sv
`default_nettype none

module fiq_class #(
    parameter int CYLINDERS = fiq_pkg::CYLINDERS_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_step,
    input  fiq_pkg::t_in_item            i_item,
    input  wire                          i_fault,
    input  wire [fiq_pkg::VOLT_W-1:0]    i_volt_thr,
    input  fiq_pkg::t_class_cfg          i_cfg,
    output fiq_pkg::t_class_rpt          o_rpt
);

    localparam int CW = (CYLINDERS > 1) ? $clog2(CYLINDERS) : 1;
    localparam int XW = (CW > fiq_pkg::CYL_W) ? CW : fiq_pkg::CYL_W;

    logic [fiq_pkg::TIMER_W-1:0] r_timer, n_timer;
    logic                        r_running, n_running;
    logic                        r_enable, n_enable;
    logic [fiq_pkg::CNT_W-1:0]   r_samples  [CYLINDERS];
    logic [fiq_pkg::CNT_W-1:0]   r_failures [CYLINDERS];
    logic [CYLINDERS-1:0]        r_done, n_done;
    logic [CYLINDERS-1:0]        r_failed, n_failed;
    logic [fiq_pkg::CNT_W-1:0]   n_samp_cyl, n_fail_cyl;

    logic                   low;
    logic                   cyl_ok;
    logic [XW-1:0]          cyl_x;
    logic [CW-1:0]          idx;
    logic [CYLINDERS-1:0]   bit_sel;
    logic [fiq_pkg::TIMER_W-1:0] t1;
    logic                   run1;
    logic [fiq_pkg::CNT_W-1:0] s_base, f_base;
    logic                   was_done;

    assign cyl_x   = XW'(i_item.cylinder);
    assign idx     = cyl_x[CW-1:0];
    assign cyl_ok  = (32'(i_item.cylinder) < 32'(CYLINDERS));
    assign bit_sel = CYLINDERS'(1) << idx;
    assign low     = (i_item.ign_voltage < i_volt_thr);

    always_comb begin
        n_timer    = r_timer;
        n_running  = r_running;
        n_enable   = r_enable;
        n_done     = r_done;
        n_failed   = r_failed;
        n_samp_cyl = '0;
        n_fail_cyl = '0;
        t1         = low ? '0 : r_timer;
        run1       = low ? 1'b0 : r_running;
        s_base     = '0;
        f_base     = '0;
        was_done   = r_done[idx];
        if (i_item.cmd == fiq_pkg::CMD_TICK) begin
            if (r_running && (r_timer != '1)) begin
                n_timer = r_timer + 1'b1;
            end
        end else begin
            n_timer   = t1;
            n_running = run1;
            if (i_item.ign_on) begin
                if (t1 >= i_cfg.delay) begin
                    n_enable  = 1'b1;
                    n_running = 1'b0;
                end else begin
                    n_enable  = 1'b0;
                    n_running = 1'b1;
                end
            end else begin
                n_enable = 1'b0;
            end

            if (low) begin
                n_done = '0;
            end
            if (cyl_ok) begin
                if (n_enable) begin
                    s_base = (low || was_done) ? '0 : r_samples[idx];
                    f_base = (low || was_done) ? '0 : r_failures[idx];
                    n_samp_cyl = (s_base == '1) ? s_base : s_base + 1'b1;
                    if (i_fault) begin
                        n_fail_cyl = (f_base == '1) ? f_base : f_base + 1'b1;
                    end else begin
                        n_fail_cyl = f_base;
                    end
                end
                n_done = n_done & ~bit_sel;
                if (n_fail_cyl >= i_cfg.fail_thr) begin
                    n_failed = n_failed | bit_sel;
                    n_done   = n_done | bit_sel;
                end else if (n_samp_cyl >= i_cfg.sample_thr) begin
                    n_failed = n_failed & ~bit_sel;
                    n_done   = n_done | bit_sel;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer   <= '0;
            r_running <= 1'b0;
            r_enable  <= 1'b0;
            r_done    <= '0;
            r_failed  <= '0;
            for (int k = 0; k < CYLINDERS; k++) begin
                r_samples[k]  <= '0;
                r_failures[k] <= '0;
            end
        end else if (i_step) begin
            r_timer   <= n_timer;
            r_running <= n_running;
            r_enable  <= n_enable;
            r_done    <= n_done;
            r_failed  <= n_failed;
            if (i_item.cmd == fiq_pkg::CMD_EVENT) begin
                for (int k = 0; k < CYLINDERS; k++) begin
                    if (cyl_ok && (idx == CW'(k))) begin
                        r_samples[k]  <= n_samp_cyl;
                        r_failures[k] <= n_fail_cyl;
                    end else if (low) begin
                        r_samples[k]  <= '0;
                        r_failures[k] <= '0;
                    end
                end
            end
        end
    end

    assign o_rpt.enable = n_enable;

    for (genvar k = 0; k < fiq_pkg::MASK_W; k++) begin : g_mask
        if (k < CYLINDERS) begin : g_on
            assign o_rpt.done[k]   = n_done[k];
            assign o_rpt.failed[k] = n_failed[k];
        end else begin : g_off
            assign o_rpt.done[k]   = 1'b0;
            assign o_rpt.failed[k] = 1'b0;
        end
    end

endmodule

`default_nettype wire

### design/ignition_output_fault_qualifier.sv
// Qualifies short-to-battery and open faults of each ignition output with a
// pair of saturating sample and failure counters per cylinder and class.
// Requests enter on the input channel (i_in_valid, o_in_ready, i_in_data):
// a tick request advances the class enable-delay timers, an event request
// evaluates enables and updates the counters of the addressed cylinder.
// Every request yields exactly one result on the output channel
// (o_out_valid, i_out_ready, o_out_data) carrying the masks and enables.
// A request is captured in an input register and its result goes into the
// result register once that is free; one request is accepted every cycle
// while the receiver does not stall. When the receiver stalls, the result
// register holds its value and the input register holds the next request;
// o_in_ready drops only once both are full. Configuration writes (i_cfg_valid,
// i_cfg_index, i_cfg_data) are always ready and take effect at once; the
// user makes them only while the block idles; the block does not enforce
// this. Reset, synchronous and active low, empties both registers, clears
// timers, enables, counters and flag bits, and loads the default thresholds.
`default_nettype none

module ignition_output_fault_qualifier #(
    parameter int CYLINDERS = fiq_pkg::CYLINDERS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  fiq_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output fiq_pkg::t_out_item             o_out_data,
    input  wire                            i_cfg_valid,
    output logic                           o_cfg_ready,
    input  wire [fiq_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [fiq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic [fiq_pkg::VOLT_W-1:0]  r_short_volt;
    logic [fiq_pkg::VOLT_W-1:0]  r_open_volt;
    logic [fiq_pkg::TIMER_W-1:0] r_delay;
    logic [fiq_pkg::CNT_W-1:0]   r_fail_thr;
    logic [fiq_pkg::CNT_W-1:0]   r_sample_thr;

    logic                        r_in_vld;
    fiq_pkg::t_in_item           r_in;
    logic                        r_out_vld;
    fiq_pkg::t_out_item          r_out;
    logic [fiq_pkg::MASK_W-1:0]  r_sticky, n_sticky;

    logic                        step;
    fiq_pkg::t_class_cfg         class_cfg;
    fiq_pkg::t_class_rpt         short_rpt, open_rpt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_volt <= '0;
            r_open_volt  <= '0;
            r_delay      <= fiq_pkg::ENABLE_DLY_RST;
            r_fail_thr   <= fiq_pkg::FAIL_THR_RST;
            r_sample_thr <= fiq_pkg::SAMPLE_THR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fiq_pkg::CFG_SHORT_VOLT: r_short_volt <= i_cfg_data;
                fiq_pkg::CFG_OPEN_VOLT:  r_open_volt  <= i_cfg_data;
                fiq_pkg::CFG_ENABLE_DLY: r_delay      <= i_cfg_data;
                fiq_pkg::CFG_FAIL_THR:   r_fail_thr   <= i_cfg_data[fiq_pkg::CNT_W-1:0];
                fiq_pkg::CFG_SAMPLE_THR: r_sample_thr <= i_cfg_data[fiq_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign class_cfg.delay      = r_delay;
    assign class_cfg.fail_thr   = r_fail_thr;
    assign class_cfg.sample_thr = r_sample_thr;

    assign step       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    fiq_class #(
        .CYLINDERS (CYLINDERS)
    ) u_short (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_in),
        .i_fault    (r_in.short_fault),
        .i_volt_thr (r_short_volt),
        .i_cfg      (class_cfg),
        .o_rpt      (short_rpt)
    );

    fiq_class #(
        .CYLINDERS (CYLINDERS)
    ) u_open (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_in),
        .i_fault    (r_in.open_fault),
        .i_volt_thr (r_open_volt),
        .i_cfg      (class_cfg),
        .o_rpt      (open_rpt)
    );

    always_comb begin
        n_sticky = r_sticky;
        if (r_in.cmd == fiq_pkg::CMD_EVENT) begin
            n_sticky = r_sticky | short_rpt.done | open_rpt.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sticky  <= '0;
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_sticky  <= n_sticky;
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out.short_failed_mask   <= short_rpt.failed;
            r_out.open_failed_mask    <= open_rpt.failed;
            r_out.short_done_mask     <= short_rpt.done;
            r_out.open_done_mask      <= open_rpt.done;
            r_out.any_done_mask       <= n_sticky;
            r_out.short_check_enabled <= short_rpt.enable;
            r_out.open_check_enabled  <= open_rpt.enable;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
